[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold on every edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hw/rtl/rdpf_pkg.sv]
// ----------------------------------------------------------------------------
// rdpf_pkg
// types, codes and constants of the duplicate packet filter
// ----------------------------------------------------------------------------
package rdpf_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;

    typedef enum logic [1:0] {
        VERDICT_NEW   = 2'd0,
        VERDICT_DUP   = 2'd1,
        VERDICT_STUN  = 2'd2,
        VERDICT_SHORT = 2'd3
    } t_verdict;

    localparam logic [BYTE_W-1:0] STUN_MAX_FIRST = 8'd2;
    localparam logic [BYTE_W-1:0] RTCP_LOW       = 8'd200;
    localparam logic [BYTE_W-1:0] RTCP_HIGH      = 8'd209;
    localparam logic [POS_W-1:0]  OFFSET_RTCP_RR = 5'd19;
    localparam logic [POS_W-1:0]  OFFSET_RTCP_SR = 5'd23;
    localparam logic [POS_W-1:0]  OFFSET_RTP     = 5'd3;
    localparam logic [POS_W-1:0]  POSITION_MAX   = 5'd31;

    // end-of-packet summary handed from the parser to the top level
    typedef struct packed {
        logic              done;
        logic              stun;
        logic              too_short;
        logic [BYTE_W-1:0] key;
    } t_pkt_end;

    typedef struct packed {
        logic [BYTE_W-1:0] key;
        t_verdict          verdict;
    } t_result;

    function automatic logic [POS_W-1:0] key_offset(input logic [BYTE_W-1:0] type_b);
        logic [POS_W-1:0] off;
        if (type_b == RTCP_LOW) begin
            off = OFFSET_RTCP_SR;
        end else if (type_b > RTCP_LOW && type_b <= RTCP_HIGH) begin
            off = OFFSET_RTCP_RR;
        end else begin
            off = OFFSET_RTP;
        end
        return off;
    endfunction

endpackage

[hw/rtl/rtp_rtcp_duplicate_packet_filter.sv]
// ----------------------------------------------------------------------------
// rtp_rtcp_duplicate_packet_filter
// classifies rtp/rtcp/stun packets and flags repeated keys
// ----------------------------------------------------------------------------
// verdict word: registered in the output register, or in the skid stage if that is held
// throughput: 1 byte per cycle while the input is not stalled; the key lookup compares all
// history cells in parallel and the push shifts the cell row in the same cycle
// output register plus a one-word skid stage; input stalls only once both
// hold a word; i_rst_n clears packet state and history at once
module rtp_rtcp_duplicate_packet_filter
    import rdpf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_packet
    input  logic [0:0]  i_s_axis_tuser,   // [0] empty_packet
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [1:0] verdict, [9:2] key_byte, zero pad
);

    `include "assert_macros.svh"

    logic     w_accept;
    t_pkt_end w_end;
    logic     w_any_match;
    logic     w_push;
    t_result  w_res;

    logic [HISTORY_DEPTH-1:0] w_valid;
    logic [HISTORY_DEPTH-1:0] w_match;
    logic [BYTE_W-1:0]        w_key [HISTORY_DEPTH];

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && !r_skid_valid;

    rdpf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_empty  (i_s_axis_tuser[0]),
        .o_end    (w_end)
    );

    // newest key enters cell 0, the oldest falls off the far end
    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        rdpf_hist_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_push),
            .i_valid_in ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g-1]),
            .i_key_in   ((g == 0) ? w_end.key : w_key[(g == 0) ? 0 : g-1]),
            .i_probe    (w_end.key),
            .o_valid    (w_valid[g]),
            .o_key      (w_key[g]),
            .o_match    (w_match[g])
        );
    end

    assign w_any_match = |w_match;
    assign w_push      = w_end.done && !w_end.stun && !w_end.too_short && !w_any_match;

    always_comb begin
        priority if (w_end.stun) begin
            w_res.verdict = VERDICT_STUN;
            w_res.key     = '0;
        end else if (w_end.too_short) begin
            w_res.verdict = VERDICT_SHORT;
            w_res.key     = '0;
        end else if (w_any_match) begin
            w_res.verdict = VERDICT_DUP;
            w_res.key     = w_end.key;
        end else begin
            w_res.verdict = VERDICT_NEW;
            w_res.key     = w_end.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid  <= r_skid_valid || w_end.done;
            r_skid_valid <= 1'b0;
        end else if (w_end.done) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_end.done) begin
            r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.key, r_out.verdict};

    // skid stage only fills behind a held output word
    `ASSERT_NEVER(a_skid_alone, i_clk, i_rst_n, r_skid_valid && !r_out_valid)
    // a stalled output catches the next verdict in the skid stage
    `ASSERT_PROP(a_skid_catch, i_clk, i_rst_n,
        (r_out_valid && !i_m_axis_tready && !r_skid_valid && w_end.done) |=> r_skid_valid)
    // a stalled skid word is kept
    `ASSERT_PROP(a_skid_hold, i_clk, i_rst_n,
        (r_skid_valid && !i_m_axis_tready) |=> (r_skid_valid && $stable(r_skid)))
    // no lookup result while input is blocked
    `ASSERT_NEVER(a_no_end_blocked, i_clk, i_rst_n, w_end.done && r_skid_valid)

    // valid cells form a contiguous run from cell 0
    for (genvar v = 1; v < HISTORY_DEPTH; v++) begin : g_chk
        `ASSERT_NEVER(a_valid_run, i_clk, i_rst_n, w_valid[v] && !w_valid[v-1])
    end

endmodule

[hw/rtl/rdpf_hist_cell.sv]
// ----------------------------------------------------------------------------
// rdpf_hist_cell
// one history slot: holds a key, compares it with the probe, shifts on push
// ----------------------------------------------------------------------------
module rdpf_hist_cell
    import rdpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_valid_in,
    input  logic [BYTE_W-1:0] i_key_in,
    input  logic [BYTE_W-1:0] i_probe,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_key,
    output logic              o_match
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_key_in;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_match = r_valid && (r_key == i_probe);

endmodule

[hw/rtl/rdpf_parser.sv]
// ----------------------------------------------------------------------------
// rdpf_parser
// per-packet byte tracking and key capture, summary on the last byte or an empty marker
// ----------------------------------------------------------------------------
module rdpf_parser
    import rdpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_empty,
    output t_pkt_end          o_end
);

    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_first;
    logic [BYTE_W-1:0] r_type;
    logic [BYTE_W-1:0] r_key;
    logic              r_key_ok;

    logic [BYTE_W-1:0] n_first;
    logic [BYTE_W-1:0] n_type;
    logic [BYTE_W-1:0] n_key;
    logic              n_key_ok;
    logic              w_hit;

    always_comb begin
        n_first = (r_pos == '0) ? i_byte : r_first;
        n_type  = (r_pos == POS_W'(1)) ? i_byte : r_type;
        w_hit   = (r_pos != '0) && !r_key_ok && (r_pos == key_offset(n_type));
        n_key   = w_hit ? i_byte : r_key;
        n_key_ok = r_key_ok || w_hit;
    end

    always_comb begin
        o_end.done      = i_accept && (i_empty || i_last);
        o_end.stun      = i_empty || (n_first <= STUN_MAX_FIRST);
        o_end.too_short = !n_key_ok;
        o_end.key       = n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_first  <= '0;
            r_type   <= '0;
            r_key    <= '0;
            r_key_ok <= 1'b0;
        end else if (i_accept) begin
            if (i_empty || i_last) begin
                r_pos    <= '0;
                r_first  <= '0;
                r_type   <= '0;
                r_key    <= '0;
                r_key_ok <= 1'b0;
            end else begin
                r_first  <= n_first;
                r_type   <= n_type;
                r_key    <= n_key;
                r_key_ok <= n_key_ok;
                if (r_pos != POSITION_MAX) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

endmodule

[test/filter_checker.sv]
// ----------------------------------------------------------------------------
// filter_checker
// watches both streams of the duplicate packet filter, predicts every
// verdict word from the accepted bytes and compares the results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module filter_checker
    import rdpf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tlast,    // end_of_packet
    input  logic [0:0]  i_s_tuser,    // [0] empty_packet
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [1:0] verdict, [9:2] key_byte, zero pad
    output int          o_mismatches,
    output int          o_pending,
    output int          o_new_seen,
    output int          o_dup_seen,
    output int          o_stun_seen,
    output int          o_short_seen
);

    typedef struct {
        t_verdict   verdict;
        logic [7:0] key;
    } t_verdict_rec;

    t_verdict_rec expected_verdicts[$];

    // packet parser copy
    logic [4:0] byte_pos;
    logic [7:0] lead_byte;
    logic [7:0] kind_byte;
    logic [7:0] held_key;
    logic       key_held;
    logic [7:0] recent_keys[$];

    function automatic logic [4:0] offset_of_kind(input logic [7:0] kind);
        logic [4:0] off;
        if (kind == RTCP_LOW) begin
            off = OFFSET_RTCP_SR;
        end else if (kind >= RTCP_LOW && kind <= RTCP_HIGH) begin
            off = OFFSET_RTCP_RR;
        end else begin
            off = OFFSET_RTP;
        end
        return off;
    endfunction

    task automatic restart_packet();
        byte_pos  = '0;
        lead_byte = '0;
        kind_byte = '0;
        held_key  = '0;
        key_held  = 1'b0;
    endtask

    task automatic expect_verdict(input t_verdict v, input logic [7:0] k);
        t_verdict_rec rec;
        rec.verdict = v;
        rec.key     = k;
        expected_verdicts.push_back(rec);
    endtask

    // one accepted byte word; a verdict is queued on the packet end only
    task automatic take_word(input logic [7:0] b, input logic last, input logic empty);
        logic found;
        found = 1'b0;
        if (empty) begin
            restart_packet();
            expect_verdict(VERDICT_STUN, 8'd0);
            return;
        end
        if (byte_pos == 5'd0) begin
            lead_byte = b;
        end else if (byte_pos == 5'd1) begin
            kind_byte = b;
        end
        if (byte_pos >= 5'd1 && !key_held && byte_pos == offset_of_kind(kind_byte)) begin
            held_key = b;
            key_held = 1'b1;
        end
        if (!last) begin
            if (byte_pos < POSITION_MAX) begin
                byte_pos++;
            end
            return;
        end
        if (lead_byte <= STUN_MAX_FIRST) begin
            expect_verdict(VERDICT_STUN, 8'd0);
        end else if (!key_held) begin
            expect_verdict(VERDICT_SHORT, 8'd0);
        end else begin
            foreach (recent_keys[i]) begin
                if (recent_keys[i] == held_key) begin
                    found = 1'b1;
                end
            end
            if (found) begin
                expect_verdict(VERDICT_DUP, held_key);
            end else begin
                if (recent_keys.size() >= HISTORY_DEPTH) begin
                    void'(recent_keys.pop_front());
                end
                recent_keys.push_back(held_key);
                expect_verdict(VERDICT_NEW, held_key);
            end
        end
        restart_packet();
    endtask

    task automatic check_word(input logic [15:0] w);
        t_verdict_rec rec;
        if (expected_verdicts.size() == 0) begin
            if (o_mismatches < 10) begin
                $display("unexpected verdict word %h at %0t", w, $realtime);
            end
            o_mismatches++;
            return;
        end
        rec = expected_verdicts.pop_front();
        case (rec.verdict)
            VERDICT_NEW:   o_new_seen++;
            VERDICT_DUP:   o_dup_seen++;
            VERDICT_STUN:  o_stun_seen++;
            VERDICT_SHORT: o_short_seen++;
            default: ;
        endcase
        if (w[1:0] !== rec.verdict || w[9:2] !== rec.key || w[15:10] !== 6'd0) begin
            if (o_mismatches < 10) begin
                $display({"verdict mismatch at %0t: expected verdict %0d key %0d, ",
                          "got verdict %0d key %0d pad %0h"},
                         $realtime, rec.verdict, rec.key, w[1:0], w[9:2], w[15:10]);
            end
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_packet();
            recent_keys.delete();
            expected_verdicts.delete();
            o_mismatches = 0;
            o_new_seen   = 0;
            o_dup_seen   = 0;
            o_stun_seen  = 0;
            o_short_seen = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                take_word(i_s_tdata, i_s_tlast, i_s_tuser[0]);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_word(i_m_tdata);
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives byte words into the duplicate packet filter: a few hand-made packets,
// then random rtp, rtcp and stun packets with broken ones mixed in, under
// bursty input and a stalling output; the checker judges every verdict word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rdpf_pkg::*;

    localparam int HISTORY_DEPTH = 4;
    localparam int RANDOM_WORDS  = 1250;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;     // end_of_packet
    logic [0:0]  s_tuser = 1'b0;     // [0] empty_packet
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [1:0] verdict, [9:2] key_byte, zero pad

    int mismatches, pending, new_seen, dup_seen, stun_seen, short_seen;

    int         words_sent = 0;
    int         packets_sent = 0;
    int         burst_left = 0;
    logic [7:0] pkt_bytes [0:47];
    int         pkt_len;
    logic [7:0] key_pool [0:5];

    t_rx_mode   rx_mode = RX_OPEN;
    int         rx_phase_left = 0;
    logic [4:0] rx_tick = '0;

    rtp_rtcp_duplicate_packet_filter #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    filter_checker #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_new_seen   (new_seen),
        .o_dup_seen   (dup_seen),
        .o_stun_seen  (stun_seen),
        .o_short_seen (short_seen)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // output side stalls in phases of differing character
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 5'd1;
        if (rx_phase_left == 0) begin
            rx_mode       <= t_rx_mode'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(20, 200);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_tready <= (rx_tick[4:3] != 2'b11);
            default:     m_tready <= 1'b1;
        endcase
    end

    // one word; a random gap follows the end of each burst
    task automatic send_word(input logic [7:0] b, input logic last, input logic empty);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= empty;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        words_sent++;
        if (last || empty) begin
            packets_sent++;
        end
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_quad(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
        send_word(b0, 1'b0, 1'b0);
        send_word(b1, 1'b0, 1'b0);
        send_word(b2, 1'b0, 1'b0);
        send_word(b3, 1'b1, 1'b0);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_len; i++) begin
            send_word(pkt_bytes[i], i == pkt_len - 1, 1'b0);
        end
    endtask

    // hold the input until every verdict has come back
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random_packet();
        int         pick;
        int         off;
        logic [7:0] kind;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 48; i++) begin
            pkt_bytes[i] = 8'($urandom_range(0, 255));
        end
        if (pick < 8) begin
            // lone empty marker, end flag either way
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 13) begin
            // packet cut off by an empty marker
            pkt_len = $urandom_range(1, 25);
            for (int i = 0; i < pkt_len; i++) begin
                send_word(pkt_bytes[i], 1'b0, 1'b0);
            end
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 20) begin
            pkt_bytes[0] = 8'($urandom_range(0, STUN_MAX_FIRST));
            pkt_len      = $urandom_range(1, 26);
            send_packet();
        end else begin
            pkt_bytes[0] = 8'($urandom_range(STUN_MAX_FIRST + 1, 255));
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                kind = RTCP_LOW;
            end else if (pick < 60) begin
                kind = 8'($urandom_range(RTCP_LOW + 1, RTCP_HIGH));
            end else if (pick < 70) begin
                kind = ($urandom_range(0, 1) != 0) ? RTCP_LOW - 8'd1 : RTCP_HIGH + 8'd1;
            end else begin
                kind = 8'($urandom_range(0, 255));
                if (kind >= RTCP_LOW && kind <= RTCP_HIGH) begin
                    kind = kind ^ 8'h40;
                end
            end
            pkt_bytes[1] = kind;
            if (kind == RTCP_LOW) begin
                off = int'(OFFSET_RTCP_SR);
            end else if (kind > RTCP_LOW && kind <= RTCP_HIGH) begin
                off = int'(OFFSET_RTCP_RR);
            end else begin
                off = int'(OFFSET_RTP);
            end
            // mostly recurring keys so that repeats and evictions happen
            if ($urandom_range(0, 9) < 7) begin
                pkt_bytes[off] = key_pool[$urandom_range(0, 5)];
            end
            if ($urandom_range(0, 15) == 0) begin
                key_pool[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                pkt_len = $urandom_range(1, off);
            end else if (pick < 95) begin
                pkt_len = $urandom_range(off + 1, off + 6);
            end else begin
                pkt_len = $urandom_range(32, 44);
            end
            send_packet();
        end
    endtask

    initial begin
        int next_drain;
        for (int i = 0; i < 6; i++) begin
            key_pool[i] = 8'($urandom_range(0, 255));
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-made packets: markers, single bytes, key extremes, repeats
        send_word(8'hA5, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h02, 1'b1, 1'b0);
        send_quad(8'h03, 8'h00, 8'h5A, 8'h00);
        send_quad(8'h80, 8'h60, 8'h12, 8'h00);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_quad(8'hFF, 8'hD2, 8'h00, 8'hFF);
        send_quad(8'h02, 8'hC8, 8'h00, 8'h33);
        drain_verdicts();

        next_drain = words_sent + 300;
        while (words_sent < RANDOM_WORDS + 25) begin
            send_random_packet();
            if (words_sent >= next_drain) begin
                drain_verdicts();
                next_drain = words_sent + $urandom_range(200, 400);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d words in %0d packets or markers", words_sent, packets_sent);
        $display("verdicts: %0d new, %0d repeated, %0d stun, %0d too short",
                 new_seen, dup_seen, stun_seen, short_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/rdpf_pkg.sv
hw/rtl/rdpf_hist_cell.sv
hw/rtl/rdpf_parser.sv
hw/rtl/rtp_rtcp_duplicate_packet_filter.sv
test/filter_checker.sv
test/tb.sv
